// ----- rtl/core/ssg_pkg.sv -----
// Shared types and constants for the Sobol sequence generator.
// No dependencies; imported by ssg_cell and the generator unit.
`default_nettype none

package ssg_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEF_MAX_DIMS   = 16;
	localparam int DEF_STATE_BITS = 32;

	// Field widths fixed by the interface
	localparam int WORD_W   = 32;
	localparam int ACTION_W = 2;
	localparam int DIMSEL_W = 4;
	localparam int BITPOS_W = 6;
	localparam int DIMCNT_W = 5;

	// Command codes
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// Input beat
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [DIMSEL_W-1:0] dimension;
		logic [BITPOS_W-1:0] bit_position;
		logic [WORD_W-1:0]   direction_word;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [WORD_W-1:0]   coordinate;
		logic [DIMSEL_W-1:0] dimension_index;
		logic                last_of_point;
		logic                exhausted;
	} res_t;

	// Control shared by every coordinate cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/ssg_cell.sv -----
// One coordinate cell of the rotating ring: holds one 32-bit coordinate.
// Depends on ssg_pkg for the cell control struct.
`default_nettype none

module ssg_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ssg_pkg::cell_ctl_t ctl,
	input  wire logic [31:0]       d_in,
	output logic      [31:0]       coord_q
);

	import ssg_pkg::*;

	// Clear on restart, take the neighbor's word on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (ctl.clear) begin
			coord_q <= '0;
		end else if (ctl.shift) begin
			coord_q <= d_in;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/sobol_sequence_generator_unit.sv -----
// Gray-code Sobol point generator: ssg_cell ring, ssg_ram direction table, ssg_pkg types.
// An advance that is not exhausted holds busy while the table is read, one read per cycle
// for each of the MAX_DIMS slots with one ring rotation per read; the next beat waits for that.
// Results come one per cycle, one per active dimension, through the sequencer state, the read
// stage and the result register; an exhausted result is registered from the accept.
// Load and restart never set busy. The receiver cannot stall. Reset clears count and coordinates, sets dims_q to 1.
`default_nettype none

module sobol_sequence_generator_unit #(
	parameter int MAX_DIMS   = ssg_pkg::DEF_MAX_DIMS,
	parameter int STATE_BITS = ssg_pkg::DEF_STATE_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire ssg_pkg::cmd_t                  cmd,
	output logic                                busy,
	output logic                                strobe,
	output ssg_pkg::res_t                       result,
	input  wire logic                           cfg_we,
	input  wire logic [ssg_pkg::DIMCNT_W-1:0]   cfg_wdata
);

	import ssg_pkg::*;

	localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AW    = $clog2(MAX_DIMS * STATE_BITS);
	localparam int NW    = 8;

	// 1 + number of trailing ones; the caller guarantees a zero bit exists
	function automatic logic [BITPOS_W-1:0] first_zero(input logic [STATE_BITS-1:0] v);
		logic [BITPOS_W-1:0] pos;
		pos = BITPOS_W'(STATE_BITS);
		for (int i = STATE_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				pos = BITPOS_W'(i + 1);
			end
		end
		return pos;
	endfunction

	seq_state_t              state_q, state_d;
	logic [DIMCNT_W-1:0]     dims_q;
	logic [STATE_BITS-1:0]   count_q;
	logic [BITPOS_W-1:0]     c_q;
	logic [DIM_W-1:0]        j_q;
	logic                    valid_s1;
	logic [DIM_W-1:0]        j_s1;
	logic                    strobe_q;
	res_t                    result_q;

	logic                    accept;
	logic                    is_advance, is_load, is_restart;
	logic                    count_full;
	logic                    issue;
	logic                    last_issue;
	logic [NW-1:0]           n_active;
	logic                    load_ok;
	logic [AW-1:0]           waddr, raddr;
	logic [WORD_W-1:0]       ram_rdata;
	logic [WORD_W-1:0]       dir_word;
	logic                    active_s1;
	logic                    last_s1;
	logic [WORD_W-1:0]       head_new;
	cell_ctl_t               cell_ctl;
	logic [WORD_W-1:0]       coord [MAX_DIMS];

	// Decode the input beat
	assign accept     = start && !busy;
	assign is_advance = (cmd.action == ACT_ADVANCE);
	assign is_load    = (cmd.action == ACT_LOAD);
	assign is_restart = (cmd.action == ACT_RESTART);
	assign count_full = &count_q;
	assign last_issue = (j_q == DIM_W'(MAX_DIMS - 1));

	// Clamp the active dimension count to 1..MAX_DIMS
	always_comb begin
		if (dims_q == '0) begin
			n_active = NW'(1);
		end else if (NW'(dims_q) > NW'(MAX_DIMS)) begin
			n_active = NW'(MAX_DIMS);
		end else begin
			n_active = NW'(dims_q);
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_advance && !count_full) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_issue) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			ST_IDLE: issue = 1'b0;
			ST_RUN:  issue = 1'b1;
			default: issue = 1'b0;
		endcase
	end

	assign busy = (state_q == ST_RUN) || valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMCNT_W'(1);
		end else if (cfg_we) begin
			dims_q <= cfg_wdata;
		end
	end

	// Point count and the direction index of the current advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			c_q     <= BITPOS_W'(1);
		end else if (accept && is_restart) begin
			count_q <= '0;
		end else if (accept && is_advance && !count_full) begin
			count_q <= count_q + 1'b1;
			c_q     <= first_zero(count_q);
		end
	end

	// Dimension counter for table reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else if (accept && is_advance) begin
			j_q <= '0;
		end else if (issue) begin
			j_q <= last_issue ? '0 : j_q + 1'b1;
		end
	end

	// Read stage tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			j_s1     <= '0;
		end else begin
			valid_s1 <= issue;
			j_s1     <= j_q;
		end
	end

	// Direction table: drop loads to dimension 0, absent slots or bad positions
	assign load_ok = accept && is_load && (cmd.dimension != '0) &&
		(NW'(cmd.dimension) < NW'(MAX_DIMS)) && (cmd.bit_position != '0) &&
		(NW'(cmd.bit_position) <= NW'(STATE_BITS));
	assign waddr = AW'(cmd.dimension * STATE_BITS + cmd.bit_position - 1);
	assign raddr = AW'(j_q * STATE_BITS + c_q - 1);

	ssg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_DIMS * STATE_BITS)
	) u_dir_ram (
		.clk  (clk),
		.we   (load_ok),
		.waddr(waddr),
		.wdata(cmd.direction_word),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Dimension 0 uses the fixed power-of-two words
	assign dir_word  = (j_s1 == '0) ? (32'h8000_0000 >> (c_q - 1'b1)) : ram_rdata;
	assign active_s1 = NW'(j_s1) < n_active;
	assign last_s1   = (NW'(j_s1) + NW'(1)) == n_active;
	assign head_new  = coord[0] ^ (active_s1 ? dir_word : '0);

	// Ring control: rotate once per read beat, clear on restart
	assign cell_ctl.shift = valid_s1;
	assign cell_ctl.clear = accept && is_restart;

	// Coordinate ring: the head cell leaves updated and re-enters at the tail
	for (genvar i = 0; i < MAX_DIMS; i++) begin : g_cell
		logic [WORD_W-1:0] d_in;
		if (i == MAX_DIMS - 1) begin : g_tail
			assign d_in = head_new;
		end else begin : g_mid
			assign d_in = coord[i+1];
		end
		ssg_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.d_in   (d_in),
			.coord_q(coord[i])
		);
	end

	// Result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else if (accept && is_advance && count_full) begin
			strobe_q <= 1'b1;
		end else begin
			strobe_q <= valid_s1 && active_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_advance && count_full) begin
			result_q.coordinate      <= '0;
			result_q.dimension_index <= '0;
			result_q.last_of_point   <= 1'b1;
			result_q.exhausted       <= 1'b1;
		end else begin
			result_q.coordinate      <= head_new;
			result_q.dimension_index <= DIMSEL_W'(j_s1);
			result_q.last_of_point   <= last_s1;
			result_q.exhausted       <= 1'b0;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire
